FILE: rtl/core/gfa_pkg.sv
// gfa_pkg: shared types, codes and default sizes for the grid rectangle allocator
// no dependencies; imported by every module of the block
`default_nettype none

package gfa_pkg;

    // default grid geometry and id width
    localparam int DEF_MAX_COLUMNS = 16;
    localparam int DEF_MAX_ROWS    = 16;
    localparam int DEF_ID_BITS     = 8;

    // fixed field widths of the request, result, configuration and apb port
    localparam int ITEM_ID_BITS = 8;
    localparam int EXTENT_BITS  = 5;
    localparam int POS_BITS     = 4;
    localparam int CFG_BITS     = 5;
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    // request command codes
    typedef enum logic {
        CMD_ADD    = 1'b0,
        CMD_REMOVE = 1'b1
    } cmd_t;

    // result status codes
    typedef enum logic [2:0] {
        ST_PLACED  = 3'd0,
        ST_NO_ROOM = 3'd1,
        ST_REMOVED = 3'd2,
        ST_ABSENT  = 3'd3,
        ST_BAD_ID  = 3'd4
    } status_t;

    // register index, taken from paddr[2]
    typedef enum logic {
        REG_COLUMNS = 1'b0,
        REG_ROWS    = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic                    cmd;
        logic [ITEM_ID_BITS-1:0] item_id;
        logic [EXTENT_BITS-1:0]  item_width;
        logic [EXTENT_BITS-1:0]  item_height;
    } req_t;

    typedef struct packed {
        status_t             status;
        logic [POS_BITS-1:0] pos_x;
        logic [POS_BITS-1:0] pos_y;
    } rsp_t;

    typedef struct packed {
        logic [CFG_BITS-1:0] grid_columns;
        logic [CFG_BITS-1:0] grid_rows;
    } cfg_t;

endpackage

`default_nettype wire

FILE: rtl/core/gfa_cfg_regs.sv
// gfa_cfg_regs: apb register file holding grid_columns and grid_rows
// depends on gfa_pkg
`default_nettype none

module gfa_cfg_regs
    import gfa_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [APB_ADDR_BITS-1:0] paddr,
    input  wire logic [APB_DATA_BITS-1:0] pwdata,
    output logic      [APB_DATA_BITS-1:0] prdata,
    output cfg_t                          cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t sel_idx;
    logic     wr_en;

    assign sel_idx = reg_idx_t'(paddr[2]);
    assign wr_en   = psel & penable & pwrite;

    // register write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (sel_idx)
                REG_COLUMNS: cfg_next.grid_columns = pwdata[CFG_BITS-1:0];
                REG_ROWS:    cfg_next.grid_rows    = pwdata[CFG_BITS-1:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.grid_columns <= CFG_BITS'(16);
            cfg_reg.grid_rows    <= CFG_BITS'(16);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // read mux
    always_comb begin
        unique case (sel_idx)
            REG_COLUMNS: prdata = APB_DATA_BITS'(cfg_reg.grid_columns);
            REG_ROWS:    prdata = APB_DATA_BITS'(cfg_reg.grid_rows);
            default:     prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: rtl/core/gfa_engine.sv
// gfa_engine: cell memory plus the sequencer that scans, fills and sweeps it
// depends on gfa_pkg
`default_nettype none

module gfa_engine
    import gfa_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int ID_BITS     = DEF_ID_BITS
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic req_valid,
    input  req_t      req,
    output logic      req_ready,
    input  cfg_t      cfg,
    input  wire logic out_free,
    output logic      rsp_valid,
    output rsp_t      rsp
);

    localparam int DEPTH     = MAX_ROWS * MAX_COLUMNS;
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CXW       = $clog2(MAX_COLUMNS + 32);
    localparam int CYW       = $clog2(MAX_ROWS + 32);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_START = 8'b0000_0100,
        S_READ  = 8'b0000_1000,
        S_CHECK = 8'b0001_0000,
        S_FILL  = 8'b0010_0000,
        S_SWEEP = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t               state_reg, state_next;
    req_t                 req_reg, req_next;
    rsp_t                 rsp_reg, rsp_next;
    logic [CXW-1:0]       x0_reg, x0_next, cx_reg, cx_next;
    logic [CYW-1:0]       y0_reg, y0_next, cy_reg, cy_next;
    logic [ADDR_BITS:0]   sweep_reg, sweep_next;
    logic                 pend_reg, pend_next;
    logic [ADDR_BITS-1:0] pend_addr_reg, pend_addr_next;
    logic                 found_reg, found_next;

    // cell memory, one write and one registered read per cycle
    logic [ID_BITS-1:0]   mem [DEPTH];
    logic [ID_BITS-1:0]   rdata_reg;
    logic                 mem_we, mem_re;
    logic [ADDR_BITS-1:0] mem_waddr, mem_raddr;
    logic [ID_BITS-1:0]   mem_wdata;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    // active geometry and request fields
    logic [CXW-1:0]       cols_act, wid, cx_inc, nx_end, rect_x_end;
    logic [CYW-1:0]       rows_act, hei, cy_inc, ny, ny_end, rect_y_end;
    logic                 id_ok, last_col, last_row;
    logic [ID_BITS-1:0]   req_id;
    logic [ADDR_BITS-1:0] cell_addr;

    assign cols_act = (CXW'(cfg.grid_columns) > CXW'(MAX_COLUMNS)) ?
                      CXW'(MAX_COLUMNS) : CXW'(cfg.grid_columns);
    assign rows_act = (CYW'(cfg.grid_rows) > CYW'(MAX_ROWS)) ?
                      CYW'(MAX_ROWS) : CYW'(cfg.grid_rows);
    assign wid      = CXW'(req_reg.item_width);
    assign hei      = CYW'(req_reg.item_height);
    assign id_ok    = (req_reg.item_id != '0) && ((req_reg.item_id >> ID_BITS) == '0);
    assign req_id   = ID_BITS'(req_reg.item_id);

    // cursor stepping and compare unit shared by scan and fill
    assign cx_inc     = cx_reg + CXW'(1);
    assign cy_inc     = cy_reg + CYW'(1);
    assign rect_x_end = x0_reg + wid;
    assign rect_y_end = y0_reg + hei;
    assign last_col   = (cx_inc >= rect_x_end);
    assign last_row   = (cy_inc >= rect_y_end);
    assign nx_end     = cx_inc + wid;
    assign ny         = y0_reg + CYW'(1);
    assign ny_end     = ny + hei;
    assign cell_addr  = ADDR_BITS'(ADDR_BITS'(cy_reg) * ADDR_BITS'(MAX_COLUMNS)
                        + ADDR_BITS'(cx_reg));

    // sequencer
    always_comb begin
        state_next     = state_reg;
        req_next       = req_reg;
        rsp_next       = rsp_reg;
        x0_next        = x0_reg;
        y0_next        = y0_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        sweep_next     = sweep_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        found_next     = found_reg;
        mem_we         = 1'b0;
        mem_waddr      = cell_addr;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = cell_addr;
        req_ready      = 1'b0;
        rsp_valid      = 1'b0;

        unique case (state_reg)
            S_CLEAR: begin
                mem_we     = 1'b1;
                mem_waddr  = sweep_reg[ADDR_BITS-1:0];
                sweep_next = sweep_reg + (ADDR_BITS+1)'(1);
                if (sweep_reg == (ADDR_BITS+1)'(DEPTH - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    req_next   = req;
                    state_next = S_START;
                end
            end
            S_START: begin
                rsp_next.pos_x = '0;
                rsp_next.pos_y = '0;
                x0_next = '0;
                y0_next = '0;
                cx_next = '0;
                cy_next = '0;
                if (!id_ok) begin
                    rsp_next.status = ST_BAD_ID;
                    state_next      = S_DONE;
                end else if (req_reg.cmd == CMD_REMOVE) begin
                    sweep_next = '0;
                    pend_next  = 1'b0;
                    found_next = 1'b0;
                    state_next = S_SWEEP;
                end else if (wid == '0 || hei == '0 || wid > cols_act ||
                             hei > rows_act) begin
                    rsp_next.status = ST_NO_ROOM;
                    state_next      = S_DONE;
                end else begin
                    state_next = S_READ;
                end
            end
            S_READ: begin
                mem_re     = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK: begin
                state_next = S_READ;
                if (rdata_reg != '0) begin
                    // every corner up to this cell in the row collides, jump past it
                    if (nx_end > cols_act) begin
                        if (ny_end > rows_act) begin
                            rsp_next.status = ST_NO_ROOM;
                            state_next      = S_DONE;
                        end
                        x0_next = '0;
                        y0_next = ny;
                        cx_next = '0;
                        cy_next = ny;
                    end else begin
                        x0_next = cx_inc;
                        cx_next = cx_inc;
                        cy_next = y0_reg;
                    end
                end else if (!last_col) begin
                    cx_next = cx_inc;
                end else if (!last_row) begin
                    cx_next = x0_reg;
                    cy_next = cy_inc;
                end else begin
                    cx_next    = x0_reg;
                    cy_next    = y0_reg;
                    state_next = S_FILL;
                end
            end
            S_FILL: begin
                mem_we    = 1'b1;
                mem_wdata = req_id;
                if (!last_col) begin
                    cx_next = cx_inc;
                end else if (!last_row) begin
                    cx_next = x0_reg;
                    cy_next = cy_inc;
                end else begin
                    rsp_next.status = ST_PLACED;
                    rsp_next.pos_x  = x0_reg[POS_BITS-1:0];
                    rsp_next.pos_y  = y0_reg[POS_BITS-1:0];
                    state_next      = S_DONE;
                end
            end
            S_SWEEP: begin
                // read one cell a cycle, clear the previous one on a match
                mem_raddr = sweep_reg[ADDR_BITS-1:0];
                pend_next = 1'b0;
                if (sweep_reg != (ADDR_BITS+1)'(DEPTH)) begin
                    mem_re         = 1'b1;
                    pend_next      = 1'b1;
                    pend_addr_next = sweep_reg[ADDR_BITS-1:0];
                    sweep_next     = sweep_reg + (ADDR_BITS+1)'(1);
                end
                if (pend_reg && rdata_reg == req_id) begin
                    mem_we     = 1'b1;
                    mem_waddr  = pend_addr_reg;
                    found_next = 1'b1;
                end
                if (sweep_reg == (ADDR_BITS+1)'(DEPTH) && !pend_reg) begin
                    rsp_next.status = found_reg ? ST_REMOVED : ST_ABSENT;
                    state_next      = S_DONE;
                end
            end
            S_DONE: begin
                rsp_valid = out_free;
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            sweep_reg <= '0;
            pend_reg  <= 1'b0;
            found_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
            pend_reg  <= pend_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg       <= req_next;
        rsp_reg       <= rsp_next;
        x0_reg        <= x0_next;
        y0_reg        <= y0_next;
        cx_reg        <= cx_next;
        cy_reg        <= cy_next;
        pend_addr_reg <= pend_addr_next;
    end

    assign rsp = rsp_reg;

endmodule

`default_nettype wire

FILE: rtl/core/grid_rect_first_fit_allocator.sv
// grid_rect_first_fit_allocator: top level with request/result channels and apb port
// depends on gfa_pkg, gfa_cfg_regs, gfa_engine
//
// Keeps a MAX_ROWS x MAX_COLUMNS grid of item ids (0 = empty) in one on-chip memory and
// serves one request at a time through a single cursor/compare unit and a sequencer.
// After reset a clearing pass writes zero to every cell with s_ready low; the
// configuration port works during it. An add scans corners in row-major order,
// examining each cell by a memory read, then a compare, and skipping past any
// occupied cell it meets, then writes the rectangle at one cell per cycle. A remove
// sweeps every memory cell. A bad id or an impossible size finishes without a scan
// or sweep. A result sits in an output register, so the next request is taken while
// the previous result waits on m_ready.
`default_nettype none

module grid_rect_first_fit_allocator
    import gfa_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int ID_BITS     = DEF_ID_BITS
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    // request channel
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic                     s_cmd,
    input  wire logic [ITEM_ID_BITS-1:0]  s_item_id,
    input  wire logic [EXTENT_BITS-1:0]   s_item_width,
    input  wire logic [EXTENT_BITS-1:0]   s_item_height,
    // result channel
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic      [2:0]               m_status,
    output logic      [POS_BITS-1:0]      m_pos_x,
    output logic      [POS_BITS-1:0]      m_pos_y,
    // configuration port
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [APB_ADDR_BITS-1:0] paddr,
    input  wire logic [APB_DATA_BITS-1:0] pwdata,
    output logic      [APB_DATA_BITS-1:0] prdata,
    output logic                          pready
);

    cfg_t cfg;
    req_t req;
    rsp_t rsp, rsp_out_reg;
    logic rsp_valid;
    logic m_valid_reg, m_valid_next;
    logic out_free;

    assign pready = 1'b1;

    gfa_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // pack the request fields
    always_comb begin
        req.cmd         = s_cmd;
        req.item_id     = s_item_id;
        req.item_width  = s_item_width;
        req.item_height = s_item_height;
    end

    gfa_engine #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS),
        .ID_BITS     (ID_BITS)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_valid),
        .req       (req),
        .req_ready (s_ready),
        .cfg       (cfg),
        .out_free  (out_free),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

    // output register
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (rsp_valid) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rsp_valid) begin
            rsp_out_reg <= rsp;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_status = rsp_out_reg.status;
    assign m_pos_x  = rsp_out_reg.pos_x;
    assign m_pos_y  = rsp_out_reg.pos_y;

endmodule

`default_nettype wire

FILE: rtl/core/gfa_checker.sv
// gfa_checker: port-level assertions for the grid rectangle allocator, with its bind
// depends on gfa_pkg and grid_rect_first_fit_allocator
`default_nettype none

module gfa_checker
    import gfa_pkg::*;
(
    input wire logic                     aclk,
    input wire logic                     aresetn,
    input wire logic                     s_valid,
    input wire logic                     s_ready,
    input wire logic                     m_valid,
    input wire logic                     m_ready,
    input wire logic [2:0]               m_status,
    input wire logic [POS_BITS-1:0]      m_pos_x,
    input wire logic [POS_BITS-1:0]      m_pos_y
);

    // a stalled result holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_pos_x)
            && $stable(m_pos_y))
        else $error("result changed while stalled");

    // only a placement carries a position
    a_pos_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_PLACED |-> m_pos_x == '0 && m_pos_y == '0)
        else $error("position set on a result that is not a placement");

    // status is a known code
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status == ST_PLACED || m_status == ST_NO_ROOM
            || m_status == ST_REMOVED || m_status == ST_ABSENT || m_status == ST_BAD_ID)
        else $error("unknown status code");

    // clearing pass keeps requests out right after reset
    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("request taken before the grid was cleared");

    // one request in work at a time
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken while one is in work");

endmodule

bind grid_rect_first_fit_allocator gfa_checker u_gfa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_status (m_status),
    .m_pos_x  (m_pos_x),
    .m_pos_y  (m_pos_y)
);

`default_nettype wire
